>>> sv/r2h_pkg.sv
// Shared types and constants for the RGB to HSV converter.
`default_nettype none
package r2h_pkg;

  localparam int unsigned ChanW  = 8;             // color channel width
  localparam int unsigned HueW   = 16;            // hue quotient bits, one per cell
  localparam int unsigned SatNumW = 2 * ChanW;    // d*255 dividend width
  localparam int unsigned HueRemW = 11;           // remainder below 6*d <= 1530
  localparam int unsigned NumCells = HueW;        // one quotient bit per cell
  localparam int unsigned InDataW  = 4 * ChanW;
  localparam int unsigned OutDataW = HueW + 3 * ChanW;

  // Payload handed from cell to cell: both long divisions in flight.
  typedef struct packed {
    logic [HueRemW-1:0] hue_rem;   // partial remainder of num / (6*d)
    logic [HueRemW-1:0] hue_den;   // 6*d, or 6 for a grey pixel
    logic [HueW-1:0]    hue_quo;   // quotient bits, newest in bit 0
    logic [ChanW-1:0]   sat_rem;   // partial remainder of d*255 / max
    logic [SatNumW-1:0] sat_num;   // dividend bits not yet brought down
    logic [ChanW-1:0]   sat_div;   // max, or 1 for a black pixel
    logic [ChanW-1:0]   sat_quo;   // quotient bits, newest in bit 0
    logic [ChanW-1:0]   value;
    logic [ChanW-1:0]   alpha;
  } r2h_cell_t;

endpackage
`default_nettype wire

>>> sv/rgb_to_hsv_unit.sv
// Top level: streaming RGBA to HSVA converter, one pixel per clock unless the output stalls.
// Pipeline: 1 setup stage + 16 divider cells between input transaction and result.
// One pixel per cycle while not stalled; each cell yields one hue and one saturation quotient bit.
// Every stage fills when empty or when its successor moves, so bubbles close under stall.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload is not reset.
`default_nettype none
module rgb_to_hsv_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, from bit 0 up: red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
  input  wire logic [r2h_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata, from bit 0 up: hue_out[15:0], saturation_out[23:16], value_out[31:24],
  // alpha_out[39:32]
  output logic [r2h_pkg::OutDataW-1:0]        m_axis_tdata
);
  import r2h_pkg::*;

  // Stage handshakes: index 0 is the setup stage, index k the k-th cell.
  logic      stg_valid [NumCells+1];
  logic      stg_ready [NumCells+1];
  r2h_cell_t stg_data  [NumCells+1];

  // Setup stage: finds max/min, picks the hue sector, wraps the red-sector
  // numerator and loads both divider operands.
  r2h_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[ChanW-1:0]),
    .green_i (s_axis_tdata[2*ChanW-1:ChanW]),
    .blue_i  (s_axis_tdata[3*ChanW-1:2*ChanW]),
    .alpha_i (s_axis_tdata[4*ChanW-1:3*ChanW]),
    .valid_o (stg_valid[0]),
    .ready_i (stg_ready[0]),
    .data_o  (stg_data[0])
  );

  // Row of divider cells. Hue needs 16 fraction bits of num/(6d); the
  // saturation division runs alongside over the 16-bit dividend d*255
  // and only its low 8 quotient bits can be nonzero.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    r2h_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .data_o  (stg_data[k+1])
    );
  end

  // Last cell register doubles as the output register.
  assign stg_ready[NumCells] = m_axis_tready;
  assign m_axis_tvalid = stg_valid[NumCells];
  assign m_axis_tdata  = {stg_data[NumCells].alpha,
                          stg_data[NumCells].value,
                          stg_data[NumCells].sat_quo,
                          stg_data[NumCells].hue_quo};

endmodule
`default_nettype wire

>>> sv/r2h_prep.sv
// Front stage: max/min, sector selection and divider operand setup.
`default_nettype none
module r2h_prep (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic [r2h_pkg::ChanW-1:0] red_i,
  input  wire logic [r2h_pkg::ChanW-1:0] green_i,
  input  wire logic [r2h_pkg::ChanW-1:0] blue_i,
  input  wire logic [r2h_pkg::ChanW-1:0] alpha_i,
  output logic                          valid_o,
  input  wire logic                     ready_i,
  output r2h_pkg::r2h_cell_t            data_o
);
  import r2h_pkg::*;

  logic              valid_q;
  r2h_cell_t         data_q, data_d;
  logic              red_max, grn_max;
  logic [ChanW-1:0]  hi, lo, d;
  logic [HueRemW-1:0] d_w, six_d, num;

  always_comb begin
    red_max = (red_i >= green_i) && (red_i >= blue_i);
    grn_max = (green_i >= blue_i);
    hi = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i > hi) hi = blue_i;
    lo = red_i;
    if (green_i < lo) lo = green_i;
    if (blue_i < lo) lo = blue_i;
    d     = hi - lo;
    d_w   = {{(HueRemW-ChanW){1'b0}}, d};
    six_d = (d_w << 2) + (d_w << 1);

    // Numerator in sixths of a turn, already wrapped into [0, 6d).
    if (red_max) begin
      if (green_i >= blue_i) begin
        num = {{(HueRemW-ChanW){1'b0}}, green_i - blue_i};
      end else begin
        num = six_d - {{(HueRemW-ChanW){1'b0}}, blue_i - green_i};
      end
    end else if (grn_max) begin
      num = (d_w << 1) + {{(HueRemW-ChanW){1'b0}}, blue_i}
          - {{(HueRemW-ChanW){1'b0}}, red_i};
    end else begin
      num = (d_w << 2) + {{(HueRemW-ChanW){1'b0}}, red_i}
          - {{(HueRemW-ChanW){1'b0}}, green_i};
    end

    // Grey and black pixels: numerators are zero, so a nonzero
    // divisor keeps the quotient at zero.
    data_d.hue_rem = num;
    data_d.hue_den = (d == '0) ? HueRemW'(6) : six_d;
    data_d.hue_quo = '0;
    data_d.sat_rem = '0;
    data_d.sat_num = ({{ChanW{1'b0}}, d} << ChanW) - {{ChanW{1'b0}}, d};
    data_d.sat_div = (hi == '0) ? ChanW'(1) : hi;
    data_d.sat_quo = '0;
    data_d.value   = hi;
    data_d.alpha   = alpha_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

>>> sv/r2h_cell.sv
// One restoring-division step for both hue and saturation quotients.
`default_nettype none
module r2h_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire r2h_pkg::r2h_cell_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output r2h_pkg::r2h_cell_t data_o
);
  import r2h_pkg::*;

  logic               valid_q;
  r2h_cell_t          data_q, data_d;
  logic [HueRemW:0]   hue_t;
  logic [ChanW:0]     sat_t;
  logic               hue_ge, sat_ge;

  always_comb begin
    data_d = data_i;
    hue_t  = {data_i.hue_rem, 1'b0};
    hue_ge = (hue_t >= {1'b0, data_i.hue_den});
    data_d.hue_rem = hue_ge ? HueRemW'(hue_t - {1'b0, data_i.hue_den})
                            : hue_t[HueRemW-1:0];
    data_d.hue_quo = {data_i.hue_quo[HueW-2:0], hue_ge};

    sat_t  = {data_i.sat_rem, data_i.sat_num[SatNumW-1]};
    sat_ge = (sat_t >= {1'b0, data_i.sat_div});
    data_d.sat_rem = sat_ge ? ChanW'(sat_t - {1'b0, data_i.sat_div})
                            : sat_t[ChanW-1:0];
    data_d.sat_num = {data_i.sat_num[SatNumW-2:0], 1'b0};
    data_d.sat_quo = {data_i.sat_quo[ChanW-2:0], sat_ge};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

>>> sv/r2h_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
`default_nettype none
module r2h_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [r2h_pkg::InDataW-1:0]  s_axis_tdata,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [r2h_pkg::OutDataW-1:0] m_axis_tdata
);
  import r2h_pkg::*;

  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat, val;

  assign hue = m_axis_tdata[HueW-1:0];
  assign sat = m_axis_tdata[HueW+ChanW-1:HueW];
  assign val = m_axis_tdata[HueW+2*ChanW-1:HueW+ChanW];

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Black pixel: no saturation and no hue.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (val == '0) |-> (sat == '0) && (hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation only for grey pixels, which carry hue zero.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (sat == '0) |-> (hue == '0))
    else $error("grey pixel with nonzero hue");

  // With the output free, the input side is never held off.
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

endmodule

bind rgb_to_hsv_unit r2h_checker u_r2h_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking stream testbench for the RGBA to HSVA converter.
module tb;
  import r2h_pkg::*;

  // Result layout as it leaves the block, hue in the lowest bits.
  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] sat;
    logic [HueW-1:0]  hue;
  } hsv_pixel_t;

  typedef struct {
    logic [InDataW-1:0] tdata;
    bit                 drain_first;  // hold off until the pipeline is empty
  } pixel_item_t;

  // Idle pattern: slow receiver first, then slow sender, then full rate.
  typedef enum int {SlowRx, SlowTx, FullRate} pace_e;

  localparam int unsigned RandomPixels = 1530;
  localparam int unsigned LongHold     = 64;  // well past the 17-deep pipeline
  localparam int unsigned TailCycles   = 40;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  pixel_item_t pixel_q[$];
  hsv_pixel_t  hsv_expect_q[$];
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_errors   = 0;
  int unsigned rx_hold    = 0;
  bit          tx_busy;

  rgb_to_hsv_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Expected HSVA for one packed RGBA pixel.
  function automatic hsv_pixel_t hsv_of_pixel(input logic [InDataW-1:0] px);
    int r, g, b, hi, lo, d, num;
    hsv_pixel_t res;
    r = int'(px[ChanW-1:0]);
    g = int'(px[2*ChanW-1:ChanW]);
    b = int'(px[3*ChanW-1:2*ChanW]);
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    d = hi - lo;
    res.alpha = px[4*ChanW-1:3*ChanW];
    res.value = ChanW'(hi);
    res.sat   = (hi == 0) ? '0 : ChanW'((d * 255) / hi);
    res.hue   = '0;
    if (d != 0) begin
      // red wins ties, then green
      if (r >= g && r >= b)      num = g - b;
      else if (g >= b)           num = 2 * d + (b - r);
      else                       num = 4 * d + (r - g);
      if (num < 0) num += 6 * d;  // wrap into one turn
      res.hue = HueW'((num << HueW) / (6 * d));
    end
    return res;
  endfunction

  function automatic logic [InDataW-1:0] rgba(input int r, input int g, input int b,
                                               input int a);
    return {ChanW'(a), ChanW'(b), ChanW'(g), ChanW'(r)};
  endfunction

  function automatic int clamp_chan(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // Random pixel, biased toward the corners of the hue math.
  function automatic logic [InDataW-1:0] rand_pixel();
    int pick, r, g, b, m, base;
    int corner[6] = '{0, 1, 127, 128, 254, 255};
    pick = $urandom_range(99);
    if (pick < 30) begin
      r = $urandom_range(255); g = $urandom_range(255); b = $urandom_range(255);
    end else if (pick < 45) begin
      // near grey: tiny max-min
      base = $urandom_range(255);
      r = clamp_chan(base + $urandom_range(6) - 3);
      g = clamp_chan(base + $urandom_range(6) - 3);
      b = clamp_chan(base + $urandom_range(6) - 3);
    end else if (pick < 60) begin
      // two channels tie for the maximum
      m = $urandom_range(255, 1);
      base = $urandom_range(m);
      case ($urandom_range(2))
        0:       begin r = m; g = m; b = base; end
        1:       begin r = m; b = m; g = base; end
        default: begin g = m; b = m; r = base; end
      endcase
    end else if (pick < 75) begin
      // red largest with blue above green: hue wraps below one turn
      r = $urandom_range(255, 2);
      b = $urandom_range(r, 1);
      g = $urandom_range(b - 1);
    end else if (pick < 85) begin
      r = corner[$urandom_range(5)];
      g = corner[$urandom_range(5)];
      b = corner[$urandom_range(5)];
    end else begin
      r = $urandom_range(3); g = $urandom_range(3); b = $urandom_range(3);
    end
    return rgba(r, g, b, $urandom_range(255));
  endfunction

  function automatic pace_e pace_now();
    if (n_accepted < 500)  return SlowRx;
    if (n_accepted < 1000) return SlowTx;
    return FullRate;
  endfunction

  function automatic int unsigned tx_idle_pct();
    case (pace_now())
      SlowRx:  return 7;
      SlowTx:  return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct();
    case (pace_now())
      SlowRx:  return 51;
      SlowTx:  return 7;
      default: return 0;
    endcase
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    n_errors++;
  endtask

  // Driver: predicts on every accepted input transaction, then offers the next
  // pixel unless idling or waiting for the pipeline to drain.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tx_busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        hsv_expect_q.push_back(hsv_of_pixel(s_axis_tdata));
        n_accepted++;
        tx_busy = 1'b0;
      end
      if (!tx_busy && pixel_q.size() != 0
          && !(pixel_q[0].drain_first && hsv_expect_q.size() != 0)
          && $urandom_range(99) >= tx_idle_pct()) begin
        s_axis_tdata <= pixel_q[0].tdata;
        pixel_q.pop_front();
        tx_busy = 1'b1;
      end
      s_axis_tvalid <= tx_busy;
    end
  end

  // Monitor: checks each result transaction against the oldest prediction and
  // drives tready, with two long holds to back the pipeline up into the input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hsv_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time,
                   m_axis_tdata);
          n_errors++;
        end else begin
          hsv_pixel_t want, got;
          want = hsv_expect_q.pop_front();
          got  = hsv_pixel_t'(m_axis_tdata);
          if (got.hue !== want.hue)     report_field("hue", want.hue, got.hue);
          if (got.sat !== want.sat)     report_field("saturation", want.sat, got.sat);
          if (got.value !== want.value) report_field("value", want.value, got.value);
          if (got.alpha !== want.alpha) report_field("alpha", want.alpha, got.alpha);
        end
        n_results++;
        if (n_results == 300 || n_results == 1200) rx_hold = LongHold;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct());
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    pixel_item_t it;
    logic [InDataW-1:0] directed[$];
    directed = '{
      rgba(0, 0, 0, 0),           // black
      rgba(255, 255, 255, 255),   // white
      rgba(128, 128, 128, 170),   // grey
      rgba(1, 1, 1, 85),
      rgba(255, 0, 0, 1),         // pure red
      rgba(0, 255, 0, 254),       // pure green
      rgba(0, 0, 255, 128),       // pure blue
      rgba(255, 255, 0, 127),     // red and green tie
      rgba(0, 255, 255, 15),      // green and blue tie
      rgba(255, 0, 255, 240),     // red and blue tie, hue wraps
      rgba(200, 10, 50, 0),       // red sector, negative offset
      rgba(255, 0, 1, 255),       // hue just below a full turn
      rgba(30, 200, 90, 60),      // green sector
      rgba(40, 20, 230, 195),     // blue sector
      rgba(1, 0, 0, 2),           // smallest non-black
      rgba(0, 0, 1, 4),
      rgba(0, 1, 0, 8),
      rgba(255, 254, 254, 16),    // barely saturated
      rgba(254, 255, 255, 32),
      rgba(128, 127, 1, 64),
      rgba(85, 170, 85, 170),
      rgba(170, 85, 255, 85)
    };
    foreach (directed[i]) begin
      it.tdata       = directed[i];
      it.drain_first = 1'b0;
      pixel_q.push_back(it);
    end
    for (int i = 0; i < RandomPixels; i++) begin
      it.tdata       = rand_pixel();
      // let the pipeline empty out now and then before going on
      it.drain_first = (i == 0 || i == 500 || i == 1000);
      pixel_q.push_back(it);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (hsv_expect_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", hsv_expect_q.size());
    $display("FAIL");
    $finish;
  end

endmodule
